>>> rtl/srpg_pkg.sv
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types, widths and register codes for the stepper ramp pulse
// generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

    localparam int REG_W     = 16;
    localparam int POS_W     = 32;
    localparam int SPEED_W   = 17;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SPEED_LIMIT    = 2'd0;
    localparam logic [1:0] REG_STOP_SPEED     = 2'd1;
    localparam logic [1:0] REG_RAMP_INCREMENT = 2'd2;
    localparam logic [1:0] REG_TICK_RATE      = 2'd3;

    localparam logic [REG_W-1:0] SPEED_LIMIT_RST    = 16'd2000;
    localparam logic [REG_W-1:0] STOP_SPEED_RST     = 16'd50;
    localparam logic [REG_W-1:0] RAMP_INCREMENT_RST = 16'd10;
    localparam logic [REG_W-1:0] TICK_RATE_RST      = 16'd50000;

    // result word bit positions
    localparam int OUT_PULSE_BIT   = 0;
    localparam int OUT_DIR_BIT     = 1;
    localparam int OUT_POS_LSB     = 2;
    localparam int OUT_SPEED_MSB   = 50;
    localparam int OUT_RUNNING_BIT = 51;

    typedef struct packed {
        logic [REG_W-1:0] speed_limit;
        logic [REG_W-1:0] stop_speed;
        logic [REG_W-1:0] ramp_increment;
        logic [REG_W-1:0] tick_rate;
    } cfg_t;

endpackage

>>> rtl/srpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// srpg_cfg_regs
// APB register file holding the four ramp settings.
// ----------------------------------------------------------------------------
module srpg_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [srpg_pkg::APB_AW-1:0] paddr,
    input  logic [srpg_pkg::APB_DW-1:0] pwdata,
    output logic [srpg_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output srpg_pkg::cfg_t             cfg
);
    import srpg_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SPEED_LIMIT:    cfg_next.speed_limit    = pwdata[REG_W-1:0];
                REG_STOP_SPEED:     cfg_next.stop_speed     = pwdata[REG_W-1:0];
                REG_RAMP_INCREMENT: cfg_next.ramp_increment = pwdata[REG_W-1:0];
                REG_TICK_RATE:      cfg_next.tick_rate      = pwdata[REG_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SPEED_LIMIT:    prdata = {16'd0, cfg_reg.speed_limit};
            REG_STOP_SPEED:     prdata = {16'd0, cfg_reg.stop_speed};
            REG_RAMP_INCREMENT: prdata = {16'd0, cfg_reg.ramp_increment};
            REG_TICK_RATE:      prdata = {16'd0, cfg_reg.tick_rate};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_limit    <= SPEED_LIMIT_RST;
            cfg_reg.stop_speed     <= STOP_SPEED_RST;
            cfg_reg.ramp_increment <= RAMP_INCREMENT_RST;
            cfg_reg.tick_rate      <= TICK_RATE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/srpg_div.sv
// ----------------------------------------------------------------------------
// srpg_div
// Restoring divider, one quotient bit per cycle, for the step interval.
// ----------------------------------------------------------------------------
module srpg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [srpg_pkg::REG_W-1:0]    dividend,
    input  logic [srpg_pkg::SPEED_W-1:0]  divisor,
    output logic                          done,
    output logic [srpg_pkg::REG_W-1:0]    quotient
);
    import srpg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [SPEED_W-1:0]   rem_reg, rem_next;
    logic [REG_W-1:0]     quo_reg, quo_next;
    logic [SPEED_W-1:0]   dvs_reg, dvs_next;
    logic [SPEED_W:0]     trial;
    logic                 fits;

    assign trial    = {rem_reg, quo_reg[REG_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract where it fits
            rem_next = fits ? SPEED_W'(trial - {1'b0, dvs_reg}) : trial[SPEED_W-1:0];
            quo_next = {quo_reg[REG_W-2:0], fits};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

>>> rtl/stepper_ramp_pulse_generator_core.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_core
// Stepper pulse generator with a linear speed ramp, one result per tick.
// ----------------------------------------------------------------------------
// Each input word is one timer tick. While the wait count is nonzero a tick
// only decrements it (and latches start_request) and its result goes
// straight to the output register. When the count is zero the block checks
// for stop (emergency stop, or target reached at or below stop_speed), and
// otherwise, while running, ramps the signed speed one ramp_increment toward
// the distance-scaled target speed (clamped to +/- speed_limit), issues one
// step and reloads the count with tick_rate / |speed|. A step tick waits on
// the restoring divider, which yields its 16 quotient bits at one per cycle.
// A tick whose ramped speed lands on zero issues no step, clears the count
// and skips the divider. s_tready is high only while the sequencer is idle,
// so one tick is in flight at a time. The result word sits in an output
// register, so a stalled m_tready holds the sequencer in its final state
// only until the register frees up. Settings are written over APB at byte
// addresses 0, 4, 8, 12 and are read directly by each state, so a write
// also affects a tick already in flight.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srpg_pkg::APB_AW-1:0]     paddr,
    input  logic [srpg_pkg::APB_DW-1:0]     pwdata,
    output logic [srpg_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    // tick input: target_position[31:0], start_request[32],
    // emergency_stop[33], zero fill
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srpg_pkg::S_TDATA_W-1:0]  s_tdata,
    // result: step_pulse[0], direction_cw[1], current_position[33:2],
    // current_speed[50:34], is_running[51], zero fill
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srpg_pkg::M_TDATA_W-1:0]  m_tdata
);
    import srpg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a tick
    localparam logic [2:0] ST_EVAL = 3'd1;  // stop check, distance
    localparam logic [2:0] ST_MUL  = 3'd2;  // distance times increment
    localparam logic [2:0] ST_RAMP = 3'd3;  // clamp target speed
    localparam logic [2:0] ST_STEP = 3'd4;  // move speed one increment
    localparam logic [2:0] ST_UPD  = 3'd5;  // step and launch divider
    localparam logic [2:0] ST_DIV  = 3'd6;  // wait for interval
    localparam logic [2:0] ST_DONE = 3'd7;  // load output register

    cfg_t cfg;

    logic [2:0]               state_reg, state_next;
    logic                     running_reg, running_next;
    logic [REG_W-1:0]         wait_reg, wait_next;
    logic signed [SPEED_W-1:0] speed_reg, speed_next;
    logic [POS_W-1:0]         position_reg, position_next;
    logic                     dir_reg, dir_next;
    logic                     pulse_reg, pulse_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;

    // per-tick working registers
    logic [POS_W-1:0]         target_reg, target_next;
    logic                     estop_reg, estop_next;
    logic signed [POS_W:0]    diff_reg, diff_next;
    logic [2*REG_W-1:0]       prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic                     big_reg, big_next;
    logic signed [SPEED_W:0]  want_reg, want_next;

    logic                     in_fire;
    logic                     out_free;
    logic [SPEED_W-1:0]       abs_speed;
    logic                     stop_now;
    logic [POS_W:0]           abs_diff;
    logic                     over_lim;
    logic [REG_W-1:0]         want_mag;
    logic signed [SPEED_W:0]  s_ext, lim_ext, inc_ext, s_up, s_dn, s_new;
    logic                     div_start;
    logic                     div_done;
    logic [REG_W-1:0]         div_quo;

    srpg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srpg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cfg.tick_rate),
        .divisor  (abs_speed),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // magnitude of the stored speed; it never reaches -2^16
    assign abs_speed = speed_reg[SPEED_W-1] ? SPEED_W'(-speed_reg) : speed_reg;

    // stop on emergency, or on target at low speed
    assign stop_now = estop_reg
                    | ((target_reg == position_reg)
                       & (abs_speed <= {1'b0, cfg.stop_speed}));

    assign abs_diff = diff_reg[POS_W] ? (POS_W+1)'(-diff_reg) : diff_reg;

    // a distance of 2^16 or more always exceeds any limit unless the increment is zero
    assign over_lim = (big_reg & (cfg.ramp_increment != '0))
                    | (prod_reg > {16'd0, cfg.speed_limit});
    assign want_mag = over_lim ? cfg.speed_limit : prod_reg[REG_W-1:0];

    assign s_ext   = {speed_reg[SPEED_W-1], speed_reg};
    assign lim_ext = {2'b00, cfg.speed_limit};
    assign inc_ext = {2'b00, cfg.ramp_increment};
    assign s_up    = s_ext + inc_ext;
    assign s_dn    = s_ext - inc_ext;

    always_comb begin
        if (want_reg > s_ext) begin
            s_new = (s_up > lim_ext) ? lim_ext : s_up;
        end else if (want_reg < s_ext) begin
            s_new = (s_dn < -lim_ext) ? -lim_ext : s_dn;
        end else begin
            s_new = s_ext;
        end
    end

    assign div_start = (state_reg == ST_UPD) && (abs_speed != '0);

    always_comb begin
        state_next    = state_reg;
        running_next  = running_reg;
        wait_next     = wait_reg;
        speed_next    = speed_reg;
        position_next = position_reg;
        dir_next      = dir_reg;
        pulse_next    = pulse_reg;
        target_next   = target_reg;
        estop_next    = estop_reg;
        diff_next     = diff_reg;
        prod_next     = prod_reg;
        neg_next      = neg_reg;
        big_next      = big_reg;
        want_next     = want_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    target_next = s_tdata[POS_W-1:0];
                    estop_next  = s_tdata[POS_W+1];
                    pulse_next  = 1'b0;
                    if (s_tdata[POS_W]) begin
                        running_next = 1'b1;
                    end
                    // count still running: decrement and report
                    if (wait_reg != '0) begin
                        wait_next  = wait_reg - 16'd1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                diff_next = {target_reg[POS_W-1], target_reg}
                          - {position_reg[POS_W-1], position_reg};
                if (stop_now) begin
                    running_next = 1'b0;
                    state_next   = ST_DONE;
                end else if (!running_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                neg_next   = diff_reg[POS_W];
                big_next   = |abs_diff[POS_W:REG_W];
                prod_next  = {16'd0, abs_diff[REG_W-1:0]} * {16'd0, cfg.ramp_increment};
                state_next = ST_RAMP;
            end
            ST_RAMP: begin
                want_next  = neg_reg ? -$signed({2'b00, want_mag})
                                     : $signed({2'b00, want_mag});
                state_next = ST_STEP;
            end
            ST_STEP: begin
                speed_next = s_new[SPEED_W-1:0];
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (abs_speed == '0) begin
                    // no step at zero speed
                    wait_next  = '0;
                    state_next = ST_DONE;
                end else begin
                    pulse_next    = 1'b1;
                    dir_next      = ~speed_reg[SPEED_W-1];
                    position_next = speed_reg[SPEED_W-1] ? position_reg - 32'd1
                                                         : position_reg + 32'd1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    wait_next  = div_quo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the word
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, running_reg, speed_reg, position_reg,
                                     dir_reg, pulse_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            running_reg  <= 1'b0;
            wait_reg     <= '0;
            speed_reg    <= '0;
            position_reg <= '0;
            dir_reg      <= 1'b1;
            pulse_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            wait_reg     <= wait_next;
            speed_reg    <= speed_next;
            position_reg <= position_next;
            dir_reg      <= dir_next;
            pulse_reg    <= pulse_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg  <= target_next;
        estop_reg   <= estop_next;
        diff_reg    <= diff_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        big_reg     <= big_next;
        want_reg    <= want_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

>>> rtl/srpg_checker.sv
// ----------------------------------------------------------------------------
// srpg_checker
// Port-level assertions for the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
module srpg_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [srpg_pkg::M_TDATA_W-1:0]  m_tdata
);
    import srpg_pkg::*;

    // one tick in flight: the input closes right after a word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted back to back");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // a step is only issued while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OUT_PULSE_BIT]) |-> m_tdata[OUT_RUNNING_BIT])
        else $error("step while stopped");

    // a step goes in the direction of the speed sign
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OUT_PULSE_BIT])
            |-> (m_tdata[OUT_DIR_BIT] == !m_tdata[OUT_SPEED_MSB]))
        else $error("direction disagrees with speed");

endmodule

bind stepper_ramp_pulse_generator_core srpg_checker u_srpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
